// ===== rtl/cesd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cesd_pkg
// Shared types and constants of the C string escape decoder.
// ----------------------------------------------------------------------------
package cesd_pkg;

  // depth of the queue between front and back, in entries
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // one entry holds every result that one input byte gives
  typedef struct packed {
    logic       two;
    logic [7:0] b0;
    logic       e0;
    logic [7:0] b1;
    logic       e1;
    logic       err;
  } res_entry_t;

endpackage : cesd_pkg
`default_nettype wire

// ===== rtl/c_escape_sequence_decoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder_top
// C string escape decoder: raw escaped bytes in, unescaped bytes out.
// ----------------------------------------------------------------------------
// One raw byte is taken per cycle whenever full is low; a byte is parsed in
// the cycle it is accepted and its results are written to a four-entry queue,
// so full rises only when that queue backs up. While pop is held and results
// wait, the result side gives one decoded byte per cycle; a non-digit byte
// that ends a hex or octal escape gives two results (one if a backslash opens
// a new escape), so a stream of such bytes is bound by the single result port.
// With the result side idle, the first result is queued and then registered.
// ----------------------------------------------------------------------------
module c_escape_sequence_decoder_top
  import cesd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       last_byte,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            end_of_string,
  output logic            octal_error
);

  res_entry_t q_wdata, q_rdata;
  logic       q_push, q_pop, q_full, q_empty;

  cesd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_byte   (in_byte),
    .last_byte (last_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  cesd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wdata   (q_wdata),
    .rd      (q_pop),
    .rdata   (q_rdata),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  cesd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_rdata       (q_rdata),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .out_byte      (out_byte),
    .end_of_string (end_of_string),
    .octal_error   (octal_error)
  );

  assign full = q_full;

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("entry written into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("entry read from empty queue");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("result side not empty after reset");

  a_queue_fill_on_idle_back: assert property (@(posedge clk) disable iff (rst)
    (!q_empty && empty) |-> q_pop)
    else $error("back stage idle while queue holds entries");
`endif

endmodule : c_escape_sequence_decoder_top
`default_nettype wire

// ===== rtl/cesd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cesd_front
// Takes raw bytes, tracks the escape parse state and builds result entries.
// ----------------------------------------------------------------------------
module cesd_front
  import cesd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic [7:0] in_byte,
  input  wire logic       last_byte,
  input  wire logic       q_full,
  output logic            q_push,
  output res_entry_t      q_wdata
);

  localparam logic [1:0] MODE_TEXT = 2'd0;
  localparam logic [1:0] MODE_ESC  = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;
  localparam logic [1:0] MODE_OCT  = 2'd3;

  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_X   = 8'h78;

  logic [1:0] mode;
  logic [7:0] val;
  logic [1:0] cnt;
  logic       err;

  logic [1:0] mode_next;
  logic [7:0] val_next;
  logic [1:0] cnt_next;
  logic       err_next;
  logic       err_upd;
  logic [1:0] nres;
  logic [7:0] b0, b1;
  logic       e0, e1;

  logic       accept;
  logic       is_dec, is_hex, plain_hold;
  logic [3:0] dig, hexv;
  logic [1:0] plain_mode;
  logic [7:0] mapped;

  assign accept = push && !q_full;

  always_comb begin
    is_dec = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    dig    = in_byte[3:0];
    hexv   = dig;
    is_hex = is_dec;
    if ((in_byte >= 8'h61 && in_byte <= 8'h66) || (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      is_hex = 1'b1;
      hexv   = 4'(in_byte[2:0] + 3'd1) + 4'd8;
    end
  end

  always_comb begin
    case (in_byte)
      8'h62:   mapped = 8'h08;
      8'h66:   mapped = 8'h0C;
      8'h6E:   mapped = 8'h0A;
      8'h72:   mapped = 8'h0D;
      8'h74:   mapped = 8'h09;
      default: mapped = in_byte;
    endcase
  end

  assign plain_hold = (in_byte == CH_BSL) && !last_byte;
  assign plain_mode = plain_hold ? MODE_ESC : MODE_TEXT;

  always_comb begin
    mode_next = mode;
    val_next  = val;
    cnt_next  = cnt;
    err_upd   = err;
    nres      = 2'd0;
    b0        = 8'h00;
    e0        = 1'b0;
    b1        = in_byte;
    e1        = last_byte;
    unique case (mode)
      MODE_ESC: begin
        if (in_byte == CH_X) begin
          mode_next = MODE_HEX;
          val_next  = 8'h00;
          cnt_next  = 2'd0;
          if (last_byte) begin
            nres = 2'd1;
            e0   = 1'b1;
          end
        end else if (is_dec) begin
          err_upd   = err | (dig > 4'd7);
          val_next  = {4'h0, dig};
          cnt_next  = 2'd1;
          mode_next = MODE_OCT;
          if (last_byte) begin
            nres = 2'd1;
            b0   = {4'h0, dig};
            e0   = 1'b1;
          end
        end else begin
          mode_next = MODE_TEXT;
          nres      = 2'd1;
          b0        = mapped;
          e0        = last_byte;
        end
      end
      MODE_HEX: begin
        if (is_hex) begin
          val_next = {val[3:0], hexv};
          if (cnt < 2'd2) cnt_next = cnt + 2'd1;
          if (last_byte) begin
            nres = 2'd1;
            b0   = {val[3:0], hexv};
            e0   = 1'b1;
          end
        end else begin
          b0        = (cnt != 2'd0) ? val : 8'h00;
          mode_next = plain_mode;
          nres      = plain_hold ? 2'd1 : 2'd2;
        end
      end
      MODE_OCT: begin
        if (is_dec) begin
          err_upd  = err | (dig > 4'd7);
          val_next = {val[4:0], 3'b000} + {4'h0, dig};
          cnt_next = cnt + 2'd1;
          if (cnt_next == 2'd3 || last_byte) begin
            nres      = 2'd1;
            b0        = val_next;
            e0        = last_byte;
            mode_next = MODE_TEXT;
            cnt_next  = 2'd0;
          end
        end else begin
          b0        = val;
          mode_next = plain_mode;
          nres      = plain_hold ? 2'd1 : 2'd2;
        end
      end
      default: begin
        mode_next = plain_mode;
        b0        = in_byte;
        e0        = last_byte;
        nres      = plain_hold ? 2'd0 : 2'd1;
      end
    endcase
    err_next = err_upd;
    if (last_byte) begin
      mode_next = MODE_TEXT;
      val_next  = 8'h00;
      cnt_next  = 2'd0;
      err_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_TEXT;
      val  <= 8'h00;
      cnt  <= 2'd0;
      err  <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      val  <= val_next;
      cnt  <= cnt_next;
      err  <= err_next;
    end
  end

  assign q_push      = accept && (nres != 2'd0);
  assign q_wdata.two = (nres == 2'd2);
  assign q_wdata.b0  = b0;
  assign q_wdata.e0  = e0;
  assign q_wdata.b1  = b1;
  assign q_wdata.e1  = e1;
  assign q_wdata.err = err_upd;

endmodule : cesd_front
`default_nettype wire

// ===== rtl/cesd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cesd_queue
// Short queue of result entries between the front and the back.
// ----------------------------------------------------------------------------
module cesd_queue
  import cesd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr,
  input  wire res_entry_t wdata,
  input  wire logic       rd,
  output res_entry_t      rdata,
  output logic            q_full,
  output logic            q_empty
);

  res_entry_t        mem [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr, do_rd;

  assign q_full  = (count == QCNT_W'(QDEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= wptr + QPTR_W'(1);
      if (do_rd) rptr <= rptr + QPTR_W'(1);
      if (do_wr && !do_rd) count <= count + QCNT_W'(1);
      else if (do_rd && !do_wr) count <= count - QCNT_W'(1);
    end
  end

endmodule : cesd_queue
`default_nettype wire

// ===== rtl/cesd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cesd_back
// Holds the current entry and hands out its results one per transaction.
// ----------------------------------------------------------------------------
module cesd_back
  import cesd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire res_entry_t q_rdata,
  input  wire logic       q_empty,
  output logic            q_pop,
  input  wire logic       pop,
  output logic            empty,
  output logic [7:0]      out_byte,
  output logic            end_of_string,
  output logic            octal_error
);

  res_entry_t cur;
  logic       valid;
  logic       idx;
  logic       last_part;
  logic       advance;

  assign last_part = !cur.two || idx;
  assign advance   = !valid || (pop && last_part);
  assign q_pop     = advance && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 1'b0;
    end else if (advance) begin
      valid <= !q_empty;
      idx   <= 1'b0;
    end else if (pop) begin
      idx <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) cur <= q_rdata;
  end

  assign empty         = !valid;
  assign out_byte      = idx ? cur.b1 : cur.b0;
  assign end_of_string = idx ? cur.e1 : cur.e0;
  assign octal_error   = cur.err;

endmodule : cesd_back
`default_nettype wire
